[src/msf_pkg.sv]
package msf_pkg;

    localparam int FRAC_BITS = 12;
    localparam int VALUE_W   = 32;
    localparam int LEVEL_W   = 20;
    localparam int STEP_W    = 24;
    localparam int ACC_W     = LEVEL_W + FRAC_BITS;
    localparam int SUM_W     = ACC_W + 1;
    localparam int REQ_W     = 2;
    localparam int M_DATA_W  = ((LEVEL_W + 7) / 8) * 8;

    localparam logic signed [LEVEL_W-1:0] VAL_MAX = LEVEL_W'((1 << (LEVEL_W - 1)) - 1);
    localparam logic signed [LEVEL_W-1:0] VAL_MIN = -VAL_MAX;

    localparam logic [REQ_W-1:0] REQ_TICK       = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET_TARGET = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SET_LEVEL  = 2'd2;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    // One accepted request after the value has been clamped.
    typedef struct packed {
        logic                       valid;
        logic [REQ_W-1:0]           req;
        logic signed [LEVEL_W-1:0]  val;
    } item_t;

endpackage

[src/msf_input_stage.sv]
module msf_input_stage
    import msf_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic signed [VALUE_W-1:0] s_value,
    input  logic [REQ_W-1:0]          s_req,
    input  logic                      take,
    output item_t                     item
);

    item_t                      item_reg;
    item_t                      item_next;
    logic signed [LEVEL_W-1:0]  clamped;

    always_comb begin
        priority if (s_value > VALUE_W'(VAL_MAX)) begin
            clamped = VAL_MAX;
        end else if (s_value < VALUE_W'(VAL_MIN)) begin
            clamped = VAL_MIN;
        end else begin
            clamped = s_value[LEVEL_W-1:0];
        end
    end

    assign s_tready = !item_reg.valid || take;

    always_comb begin
        item_next = item_reg;
        if (s_tvalid && s_tready) begin
            item_next.valid = 1'b1;
            item_next.req   = s_req;
            item_next.val   = clamped;
        end else if (take) begin
            item_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
        end else begin
            item_reg.valid <= item_next.valid;
        end
        item_reg.req <= item_next.req;
        item_reg.val <= item_next.val;
    end

    assign item = item_reg;

endmodule

[src/msf_update.sv]
module msf_update
    import msf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  item_t                item,
    output logic                 take,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [STEP_W-1:0]    cfg_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [LEVEL_W-1:0]   m_level
);

    logic [STEP_W-1:0]         step_reg;
    logic signed [ACC_W-1:0]   cur_reg,  cur_next;
    logic signed [ACC_W-1:0]   tgt_reg,  tgt_next;
    dir_t                      dir_reg,  dir_next;
    logic                      out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]        out_level_reg, out_level_next;

    logic signed [ACC_W-1:0]   scaled;
    logic signed [SUM_W-1:0]   cur_w;
    logic signed [SUM_W-1:0]   tgt_w;
    logic signed [SUM_W-1:0]   step_w;
    logic signed [SUM_W-1:0]   sum;
    logic signed [ACC_W-1:0]   tick_level;
    dir_t                      tick_dir;
    logic signed [LEVEL_W-1:0] whole;
    logic                      fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (cfg_valid) begin
            step_reg <= cfg_data;
        end
    end

    assign scaled = {item.val, {FRAC_BITS{1'b0}}};
    assign cur_w  = SUM_W'(cur_reg);
    assign tgt_w  = SUM_W'(tgt_reg);
    assign step_w = $signed({{(SUM_W - STEP_W){1'b0}}, step_reg});

    // One tick: step in the set direction, if any; snap onto a target reached or passed.
    always_comb begin
        tick_level = cur_reg;
        tick_dir   = dir_reg;
        sum        = cur_w;
        if (cur_reg != tgt_reg) begin
            if (dir_reg == DIR_DOWN) begin
                sum = cur_w - step_w;
                if (sum <= tgt_w) begin
                    tick_level = tgt_reg;
                    tick_dir   = DIR_NONE;
                end else begin
                    tick_level = sum[ACC_W-1:0];
                end
            end else begin
                if (dir_reg == DIR_UP) begin
                    sum = cur_w + step_w;
                end
                if (tgt_w <= sum) begin
                    tick_level = tgt_reg;
                    tick_dir   = DIR_NONE;
                end else begin
                    tick_level = sum[ACC_W-1:0];
                end
            end
        end
    end

    // Arithmetic shift rounds toward minus infinity; bump negatives with a fraction back up.
    assign whole = tick_level[ACC_W-1:FRAC_BITS]
                 + LEVEL_W'(tick_level[ACC_W-1] && (|tick_level[FRAC_BITS-1:0]));

    assign take = item.valid && (item.req != REQ_TICK || !out_valid_reg || m_tready);
    assign fire = item.valid && take;

    always_comb begin
        cur_next       = cur_reg;
        tgt_next       = tgt_reg;
        dir_next       = dir_reg;
        out_level_next = out_level_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (fire) begin
            unique case (item.req)
                REQ_TICK: begin
                    cur_next       = tick_level;
                    dir_next       = tick_dir;
                    out_valid_next = 1'b1;
                    out_level_next = whole;
                end
                REQ_SET_TARGET: begin
                    tgt_next = scaled;
                    if (scaled == cur_reg) begin
                        dir_next = DIR_NONE;
                    end else if (scaled > cur_reg) begin
                        dir_next = DIR_UP;
                    end else begin
                        dir_next = DIR_DOWN;
                    end
                end
                REQ_SET_LEVEL: begin
                    cur_next = scaled;
                    dir_next = DIR_NONE;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg       <= '0;
            tgt_reg       <= '0;
            dir_reg       <= DIR_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            cur_reg       <= cur_next;
            tgt_reg       <= tgt_next;
            dir_reg       <= dir_next;
            out_valid_reg <= out_valid_next;
        end
        out_level_reg <= out_level_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_level  = out_level_reg;

endmodule

[src/modulation_slew_follower_core.sv]
// Path: a tick is held in the input register, then its level is held in the output register,
// from which it shows on m_tdata and can be transferred out.
// Throughput: one request per cycle, set and tick requests mixed freely, as long as m_tready
// stays high. While a result is stalled, set requests still pass, but the next tick waits in
// the input register and holds up every request behind it until the result is taken.
// Reset: aresetn is synchronous and active low; it clears the level, the target, the
// direction and step_rate to zero and empties both the input and the output register.
module modulation_slew_follower_core
    import msf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [VALUE_W-1:0]      s_tdata,   // [31:0] value (signed)
    input  logic [REQ_W-1:0]        s_tuser,   // [1:0] req_type
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_DATA_W-1:0]     m_tdata,   // [19:0] level (signed), upper bits zero
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [STEP_W-1:0]       cfg_data   // [23:0] step_rate
);

    item_t              item;
    logic               take;
    logic [LEVEL_W-1:0] level;

    msf_input_stage u_input (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_value  ($signed(s_tdata)),
        .s_req    (s_tuser),
        .take     (take),
        .item     (item)
    );

    msf_update u_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (item),
        .take      (take),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_level   (level)
    );

    assign m_tdata = {{(M_DATA_W - LEVEL_W){1'b0}}, level};

endmodule

[src/msf_checker.sv]
module msf_checker
    import msf_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // Nothing is left in the output register after a reset cycle.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // A stalled result stays put until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The level never leaves its clamped range, and the padding stays zero.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[LEVEL_W-1:0] != {1'b1, {(LEVEL_W - 1){1'b0}}}
                     && m_tdata[M_DATA_W-1:LEVEL_W] == '0)
        else $error("level out of range");

    // With the output free or draining, the input side never stalls.
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) && $past(!m_tvalid || m_tready) && $past(aresetn)
        |-> s_tready)
        else $error("input stalled while output was free");

endmodule

bind modulation_slew_follower_core msf_checker u_msf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import msf_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int LONG_HOLD    = 200;
    localparam int SETTLE_TICKS = 6;

    typedef struct {
        logic [REQ_W-1:0]   req;
        logic [VALUE_W-1:0] value;
    } follower_req_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata   = '0;
    logic [REQ_W-1:0]    s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [STEP_W-1:0]   cfg_data  = '0;

    modulation_slew_follower_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [31:0] value (signed)
        .s_tuser   (s_tuser),    // [1:0] req_type
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [19:0] level (signed), upper bits zero
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)    // [23:0] step_rate
    );

    always #5 aclk = ~aclk;

    // Follower state as seen from outside, advanced on every accepted request.
    longint            lvl_acc  = 0;
    longint            tgt_acc  = 0;
    dir_t              ramp_dir = DIR_NONE;
    logic [STEP_W-1:0] step_cfg = '0;

    follower_req_t             pending_reqs[$];
    logic signed [LEVEL_W-1:0] level_expect[$];
    follower_req_t             cur_req;

    int queued_count  = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int err_count     = 0;
    int step_writes   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    logic hold_armed = 1'b0;
    logic hold_done  = 1'b0;
    int   hold_count = 0;

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic longint clamp_to_acc(logic [VALUE_W-1:0] raw);
        logic signed [VALUE_W-1:0] v;
        v = raw;
        if (v > VAL_MAX)
            v = VAL_MAX;
        else if (v < VAL_MIN)
            v = VAL_MIN;
        return longint'(v) * (longint'(1) << FRAC_BITS);
    endfunction

    task automatic follow_request(follower_req_t it);
        longint t;
        longint whole;
        case (it.req)
            REQ_SET_TARGET: begin
                t = clamp_to_acc(it.value);
                if (t == lvl_acc)
                    ramp_dir = DIR_NONE;
                else if (t > lvl_acc)
                    ramp_dir = DIR_UP;
                else
                    ramp_dir = DIR_DOWN;
                tgt_acc = t;
            end
            REQ_SET_LEVEL: begin
                lvl_acc  = clamp_to_acc(it.value);
                ramp_dir = DIR_NONE;
            end
            REQ_TICK: begin
                if (lvl_acc != tgt_acc) begin
                    if (ramp_dir == DIR_DOWN) begin
                        lvl_acc -= longint'(step_cfg);
                        if (lvl_acc <= tgt_acc) begin
                            lvl_acc  = tgt_acc;
                            ramp_dir = DIR_NONE;
                        end
                    end else begin
                        // Without a direction the level stays put, but still snaps
                        // down to a target that lies at or below it.
                        if (ramp_dir == DIR_UP)
                            lvl_acc += longint'(step_cfg);
                        if (tgt_acc <= lvl_acc) begin
                            lvl_acc  = tgt_acc;
                            ramp_dir = DIR_NONE;
                        end
                    end
                end
                whole = lvl_acc / (longint'(1) << FRAC_BITS);
                level_expect.push_back(whole[LEVEL_W-1:0]);
            end
            default: ;
        endcase
    endtask

    // Request driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                follow_request(cur_req);
                sent_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_req.value;
                    s_tuser  <= cur_req.req;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // The long receiver hold-off is timed here, apart from the ready pattern.
    always @(posedge aclk) begin
        if (hold_armed && !hold_done) begin
            if (hold_count == LONG_HOLD - 1)
                hold_done <= 1'b1;
            hold_count <= hold_count + 1;
        end
    end

    always @(posedge aclk) begin
        m_tready <= !(hold_armed && !hold_done) && ($urandom_range(99) >= recv_idle_pct);
    end

    // Level monitor.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (level_expect.size() == 0) begin
                report_mismatch($sformatf("level %0d with no tick outstanding",
                                          $signed(m_tdata[LEVEL_W-1:0])));
            end else begin
                logic signed [LEVEL_W-1:0] want;
                want = level_expect.pop_front();
                if (m_tdata[LEVEL_W-1:0] !== want)
                    report_mismatch($sformatf("level %0d, expected %0d",
                                              $signed(m_tdata[LEVEL_W-1:0]), want));
                checked_count++;
            end
        end
    end

    task automatic push_item(logic [REQ_W-1:0] req, logic [VALUE_W-1:0] value);
        follower_req_t it;
        it.req   = req;
        it.value = value;
        pending_reqs.push_back(it);
        queued_count++;
    endtask

    // Waits until every queued request has gone in and every level has come out.
    task automatic drain();
        while (sent_count != queued_count || level_expect.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_step(logic [STEP_W-1:0] v);
        drain();
        // Set requests produce no level, so give the pipeline time to empty.
        repeat (SETTLE_TICKS) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        step_cfg = v;
        step_writes++;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(5))
                    0: return 32'h7fffffff;
                    1: return 32'h80000000;
                    2: return 32'd524288;
                    3: return 32'(-524288);
                    4: return 32'd524287;
                    default: return 32'(-524287);
                endcase
            end
            1: return $urandom;
            default: return 32'(int'($urandom_range(1048574)) - 524287);
        endcase
    endfunction

    // Mostly ramps (level, target, a run of ticks), with some noise and cut-short ramps.
    task automatic push_random(int n);
        int start;
        int ticks;
        int span;
        int base;
        int goal;
        start = queued_count;
        while (queued_count - start < n) begin
            case ($urandom_range(9))
                0: push_item(REQ_W'($urandom_range(3)), $urandom);
                1: begin
                    push_item(REQ_SET_TARGET, pick_value());
                    if ($urandom_range(1))
                        push_item(REQ_SET_LEVEL, pick_value());
                    push_item(REQ_TICK, $urandom);
                end
                default: begin
                    ticks = $urandom_range(1, 16);
                    span  = int'((longint'(step_cfg) * ticks) >>> FRAC_BITS) * 2 + 3;
                    if (span > 1048574)
                        span = 1048574;
                    base = int'($urandom_range(1048574)) - 524287;
                    if ($urandom_range(2) != 0)
                        push_item(REQ_SET_LEVEL, 32'(base));
                    goal = base + int'($urandom_range(2 * span)) - span;
                    push_item(REQ_SET_TARGET, 32'(goal));
                    for (int k = 0; k < ticks; k++)
                        push_item(REQ_TICK, $urandom);
                    if ($urandom_range(3) == 0) begin
                        push_item(REQ_SET_TARGET, 32'(base));
                        push_item(REQ_TICK, $urandom);
                    end
                end
            endcase
        end
    endtask

    initial begin
        int n;
        send_idle_pct = 29;
        recv_idle_pct = 68;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: three and a bit whole units per tick.
        write_step(24'h003005);
        push_item(REQ_TICK, 32'hffffffff);
        push_item(REQ_UNUSED, 32'hffffffff);
        push_item(REQ_TICK, 32'h0);
        push_item(REQ_SET_LEVEL, 32'h7fffffff);
        push_item(REQ_TICK, 32'h0);
        push_item(REQ_SET_LEVEL, 32'd524288);
        push_item(REQ_TICK, 32'h0);
        push_item(REQ_SET_LEVEL, 32'h80000000);
        push_item(REQ_TICK, 32'h0);
        push_item(REQ_SET_LEVEL, 32'(-524288));
        push_item(REQ_SET_TARGET, 32'(-524287));
        push_item(REQ_TICK, 32'h0);
        push_item(REQ_SET_TARGET, 32'(-524280));
        repeat (3) push_item(REQ_TICK, 32'h0);
        push_item(REQ_SET_TARGET, 32'(-524290));
        repeat (3) push_item(REQ_TICK, 32'h0);
        push_item(REQ_SET_TARGET, 32'd50);
        push_item(REQ_SET_LEVEL, 32'd100);
        push_item(REQ_TICK, 32'h0);
        push_item(REQ_SET_LEVEL, 32'd10);
        push_item(REQ_TICK, 32'h0);
        push_item(REQ_SET_TARGET, 32'd20);
        push_item(REQ_TICK, 32'h0);

        write_step(24'hffffff);
        push_random(100);
        write_step(24'h000000);
        push_random(100);

        send_idle_pct = 68;
        recv_idle_pct = 29;
        write_step(24'h000001);
        push_random(60);
        // Sender pauses here until the follower has caught up completely.
        drain();
        push_random(50);
        write_step(24'(($urandom % 16) * 4096 + $urandom_range(4095)));
        push_random(100);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_step(24'h001000);
        hold_armed <= 1'b1;
        push_item(REQ_SET_LEVEL, 32'(-300));
        push_item(REQ_SET_TARGET, 32'd300);
        repeat (60) push_item(REQ_TICK, $urandom);
        write_step(24'($urandom));
        push_random(100);
        write_step(24'($urandom_range(40000)));
        push_random(60);

        while (sent_count != queued_count)
            @(posedge aclk);
        for (n = 0; n < 5000 && level_expect.size() != 0; n++)
            @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (level_expect.size() != 0)
            report_mismatch($sformatf("%0d levels never arrived", level_expect.size()));

        $display("Sent %0d requests and checked %0d levels across %0d step settings,",
                 sent_count, checked_count, step_writes);
        $display("from zero to full scale, with a %0d-cycle output hold-off.", LONG_HOLD);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
